>>> rtl/core/dcmas_pkg.sv
// ----------------------------------------------------------------------------
// dcmas_pkg
// Shared widths, presets and register indices for the dual-channel
// moving-average scaler.
// ----------------------------------------------------------------------------
package dcmas_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int SCALED_W    = 17;
  localparam int SCALE_SHIFT = 16;

  localparam int WINDOW_DEFAULT = 10;

  localparam logic [SAMPLE_W-1:0] TEMP_PRESET = 16'h66DB;
  localparam logic [SAMPLE_W-1:0] HUM_PRESET  = 16'h6076;

  localparam logic CH_TEMP = 1'b0;
  localparam logic CH_HUM  = 1'b1;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_GAIN    = 2'd2;

  localparam logic [GAIN_W-1:0] TEMP_GAIN_RESET   = 16'd175;
  localparam logic [GAIN_W-1:0] TEMP_OFFSET_RESET = 16'd45;
  localparam logic [GAIN_W-1:0] HUM_GAIN_RESET    = 16'd100;

endpackage

>>> rtl/core/dual_channel_moving_average_scaler_top.sv
// ----------------------------------------------------------------------------
// dual_channel_moving_average_scaler_top
// Per-channel boxcar average of raw samples, linear scaling and running
// extremes of the scaled value.
//
//   channel   dir  handshake              payload
//   input     in   in_valid / in_ready    channel, sample
//   result    out  out_valid / out_ready  out_channel, mean_raw, scaled,
//                                         running_max, running_min
//   config    in   cfg_we (no wait)       cfg_index, cfg_data
//
// One transaction per cycle sustained while out_ready keeps the result side
// moving. From input acceptance to out_valid the sum register loads at
// acceptance, then the reciprocal divide, gain multiply and extreme update
// registers follow. Each stage holds only when the stage after it is full and
// stalled, so bubbles are squeezed out under a stalled output.
// rst is synchronous: windows reload their presets, extremes clear to zero
// and the gains and offset take their defaults.
// ----------------------------------------------------------------------------
module dual_channel_moving_average_scaler_top #(
  parameter int WINDOW = dcmas_pkg::WINDOW_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  channel,
  input  logic        [dcmas_pkg::SAMPLE_W-1:0] sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_channel,
  output logic        [dcmas_pkg::SAMPLE_W-1:0] mean_raw,
  output logic signed [dcmas_pkg::SCALED_W-1:0] scaled,
  output logic signed [dcmas_pkg::SCALED_W-1:0] running_max,
  output logic signed [dcmas_pkg::SCALED_W-1:0] running_min,
  input  logic                                  cfg_we,
  input  logic       [dcmas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic           [dcmas_pkg::CFG_W-1:0] cfg_data
);

  localparam int SW        = dcmas_pkg::SAMPLE_W;
  localparam int GW        = dcmas_pkg::GAIN_W;
  localparam int QW        = dcmas_pkg::SCALED_W;
  localparam int SUM_W     = SW + $clog2(WINDOW);
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int MUL_W     = SUM_W + 2;
  localparam int PROD_W    = SUM_W + MUL_W;
  localparam int SCL_W     = SW + GW;

  localparam longint unsigned DivMulL =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] DIV_MUL = MUL_W'(DivMulL);

  localparam logic [SUM_W-1:0] TEMP_SUM_RESET =
    SUM_W'(64'(WINDOW) * 64'(dcmas_pkg::TEMP_PRESET));
  localparam logic [SUM_W-1:0] HUM_SUM_RESET =
    SUM_W'(64'(WINDOW) * 64'(dcmas_pkg::HUM_PRESET));

  // configuration
  logic [GW-1:0] temp_gain;
  logic [GW-1:0] temp_offset;
  logic [GW-1:0] hum_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_gain   <= dcmas_pkg::TEMP_GAIN_RESET;
      temp_offset <= dcmas_pkg::TEMP_OFFSET_RESET;
      hum_gain    <= dcmas_pkg::HUM_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dcmas_pkg::REG_TEMP_GAIN:   temp_gain   <= cfg_data;
        dcmas_pkg::REG_TEMP_OFFSET: temp_offset <= cfg_data;
        dcmas_pkg::REG_HUM_GAIN:    hum_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage flow control
  logic v1, v2, v3;
  logic o_free, s3_free, s2_free, s1_free, accept;

  assign o_free  = !out_valid || out_ready;
  assign s3_free = !v3 || o_free;
  assign s2_free = !v2 || s3_free;
  assign s1_free = !v1 || s2_free;
  assign in_ready = s1_free;
  assign accept   = in_valid && s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) v1 <= in_valid;
      if (s2_free) v2 <= v1;
      if (s3_free) v3 <= v2;
      if (o_free)  out_valid <= v3;
    end
  end

  // windows and running sums
  logic [SW-1:0]    temp_hist [WINDOW];
  logic [SW-1:0]    hum_hist  [WINDOW];
  logic [SUM_W-1:0] temp_sum;
  logic [SUM_W-1:0] hum_sum;
  logic [SUM_W-1:0] temp_sum_next;
  logic [SUM_W-1:0] hum_sum_next;

  assign temp_sum_next = temp_sum - SUM_W'(temp_hist[0]) + SUM_W'(sample);
  assign hum_sum_next  = hum_sum  - SUM_W'(hum_hist[0])  + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        temp_hist[i] <= dcmas_pkg::TEMP_PRESET;
        hum_hist[i]  <= dcmas_pkg::HUM_PRESET;
      end
      temp_sum <= TEMP_SUM_RESET;
      hum_sum  <= HUM_SUM_RESET;
    end else if (accept) begin
      if (channel == dcmas_pkg::CH_TEMP) begin
        for (int i = 0; i < WINDOW - 1; i++) temp_hist[i] <= temp_hist[i+1];
        temp_hist[WINDOW-1] <= sample;
        temp_sum <= temp_sum_next;
      end else begin
        for (int i = 0; i < WINDOW - 1; i++) hum_hist[i] <= hum_hist[i+1];
        hum_hist[WINDOW-1] <= sample;
        hum_sum <= hum_sum_next;
      end
    end
  end

  // stage 1: new window sum
  logic             s1_ch;
  logic [SUM_W-1:0] s1_sum;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch  <= channel;
      s1_sum <= (channel == dcmas_pkg::CH_TEMP) ? temp_sum_next : hum_sum_next;
    end
  end

  // stage 2: floor mean by reciprocal multiply
  logic [PROD_W-1:0] div_prod;
  logic              s2_ch;
  logic [SW-1:0]     s2_mean;

  assign div_prod = PROD_W'(s1_sum) * PROD_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (v1 && s2_free) begin
      s2_ch   <= s1_ch;
      s2_mean <= div_prod[DIV_SHIFT +: SW];
    end
  end

  // stage 3: gain and offset
  logic [GW-1:0]        gain_sel;
  logic [GW-1:0]        offset_sel;
  logic [SCL_W-1:0]     scl_prod;
  logic signed [QW-1:0] scaled_next;
  logic                 s3_ch;
  logic [SW-1:0]        s3_mean;
  logic signed [QW-1:0] s3_scaled;

  assign gain_sel   = (s2_ch == dcmas_pkg::CH_TEMP) ? temp_gain : hum_gain;
  assign offset_sel = (s2_ch == dcmas_pkg::CH_TEMP) ? temp_offset : '0;
  assign scl_prod   = SCL_W'(s2_mean) * SCL_W'(gain_sel);
  assign scaled_next = $signed({1'b0, scl_prod[dcmas_pkg::SCALE_SHIFT +: SW]})
                     - $signed({1'b0, offset_sel});

  always_ff @(posedge clk) begin
    if (v2 && s3_free) begin
      s3_ch     <= s2_ch;
      s3_mean   <= s2_mean;
      s3_scaled <= scaled_next;
    end
  end

  // stage 4: extremes and result register
  logic signed [QW-1:0] temp_peak, temp_floor, hum_peak, hum_floor;
  logic signed [QW-1:0] peak_cur, floor_cur, peak_next, floor_next;

  assign peak_cur   = (s3_ch == dcmas_pkg::CH_TEMP) ? temp_peak : hum_peak;
  assign floor_cur  = (s3_ch == dcmas_pkg::CH_TEMP) ? temp_floor : hum_floor;
  assign peak_next  = (peak_cur < s3_scaled) ? s3_scaled : peak_cur;
  assign floor_next = (floor_cur > s3_scaled) ? s3_scaled : floor_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_peak  <= '0;
      temp_floor <= '0;
      hum_peak   <= '0;
      hum_floor  <= '0;
    end else if (v3 && o_free) begin
      if (s3_ch == dcmas_pkg::CH_TEMP) begin
        temp_peak  <= peak_next;
        temp_floor <= floor_next;
      end else begin
        hum_peak   <= peak_next;
        hum_floor  <= floor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && o_free) begin
      out_channel <= s3_ch;
      mean_raw    <= s3_mean;
      scaled      <= s3_scaled;
      running_max <= peak_next;
      running_min <= floor_next;
    end
  end

  // checks
  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (running_max >= scaled) && (running_max >= 0))
    else $error("running_max below scaled value or zero");

  a_min_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (running_min <= scaled) && (running_min <= 0))
    else $error("running_min above scaled value or zero");

  a_hum_positive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_channel == dcmas_pkg::CH_HUM) |-> !scaled[QW-1])
    else $error("humidity scaled value negative");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> v1)
    else $error("accepted transaction lost at first stage");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual-channel moving-average scaler. A small
// scoreboard mirrors both sample windows, the running sums, the gain/offset
// registers and the per-channel extremes, and predicts every result. The
// input and result channels idle at random, one phase stalls the result side
// for a long stretch, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SAMPLE_W    = dcmas_pkg::SAMPLE_W;
  localparam int GAIN_W      = dcmas_pkg::GAIN_W;
  localparam int SCALED_W    = dcmas_pkg::SCALED_W;
  localparam int CFG_W       = dcmas_pkg::CFG_W;
  localparam int CFG_IDX_W   = dcmas_pkg::CFG_IDX_W;

  localparam int WIN          = dcmas_pkg::WINDOW_DEFAULT;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_CYCLES = 200;
  localparam int LIMIT        = 1000;
  localparam int PHASE_ITEMS  = 100;

  // index past the last register: writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic                       ch;
    logic [SAMPLE_W-1:0]        mean;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [SCALED_W-1:0] maxv;
    logic signed [SCALED_W-1:0] minv;
  } avg_result_t;

  class avg_scoreboard;
    logic [SAMPLE_W-1:0] hist [2][WIN];
    logic [19:0]         sum [2];
    int                  peak [2];
    int                  trough [2];
    logic [GAIN_W-1:0]   gain [2];
    logic [GAIN_W-1:0]   temp_offset;
    avg_result_t         result_q [$];
    int                  errors;

    function new();
      errors = 0;
      gain[dcmas_pkg::CH_TEMP] = dcmas_pkg::TEMP_GAIN_RESET;
      gain[dcmas_pkg::CH_HUM]  = dcmas_pkg::HUM_GAIN_RESET;
      temp_offset              = dcmas_pkg::TEMP_OFFSET_RESET;
      for (int i = 0; i < WIN; i++) begin
        hist[dcmas_pkg::CH_TEMP][i] = dcmas_pkg::TEMP_PRESET;
        hist[dcmas_pkg::CH_HUM][i]  = dcmas_pkg::HUM_PRESET;
      end
      sum[dcmas_pkg::CH_TEMP] = 20'(WIN * dcmas_pkg::TEMP_PRESET);
      sum[dcmas_pkg::CH_HUM]  = 20'(WIN * dcmas_pkg::HUM_PRESET);
      for (int c = 0; c < 2; c++) begin
        peak[c]   = 0;
        trough[c] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        dcmas_pkg::REG_TEMP_GAIN:   gain[dcmas_pkg::CH_TEMP] = data;
        dcmas_pkg::REG_TEMP_OFFSET: temp_offset = data;
        dcmas_pkg::REG_HUM_GAIN:    gain[dcmas_pkg::CH_HUM] = data;
        default: ;
      endcase
    endfunction

    function void note_input(logic ch, logic [SAMPLE_W-1:0] smp);
      avg_result_t e;
      logic [31:0] prod;
      int          sc;
      sum[ch] = sum[ch] - 20'(hist[ch][0]) + 20'(smp);
      for (int i = 0; i < WIN - 1; i++) hist[ch][i] = hist[ch][i+1];
      hist[ch][WIN-1] = smp;
      e.ch   = ch;
      e.mean = SAMPLE_W'(sum[ch] / 20'(WIN));
      prod   = 32'(e.mean) * 32'(gain[ch]);
      sc     = int'(prod >> dcmas_pkg::SCALE_SHIFT)
             - ((ch == dcmas_pkg::CH_TEMP) ? int'(temp_offset) : 0);
      if (peak[ch] < sc) peak[ch] = sc;
      if (trough[ch] > sc) trough[ch] = sc;
      e.scaled = SCALED_W'(sc);
      e.maxv   = SCALED_W'(peak[ch]);
      e.minv   = SCALED_W'(trough[ch]);
      result_q.push_back(e);
    endfunction

    function void check_result(logic ch, logic [SAMPLE_W-1:0] mean,
                               logic signed [SCALED_W-1:0] sc,
                               logic signed [SCALED_W-1:0] mx,
                               logic signed [SCALED_W-1:0] mn);
      avg_result_t e;
      if (result_q.size() == 0) begin
        $error("unexpected result transaction: channel %0d mean %0d", ch, mean);
        errors++;
        return;
      end
      e = result_q.pop_front();
      if (ch !== e.ch) begin
        $error("out_channel: expected %0d, got %0d", e.ch, ch);
        errors++;
      end
      if (mean !== e.mean) begin
        $error("mean_raw: expected %0d, got %0d", e.mean, mean);
        errors++;
      end
      if (sc !== e.scaled) begin
        $error("scaled: expected %0d, got %0d", e.scaled, sc);
        errors++;
      end
      if (mx !== e.maxv) begin
        $error("running_max: expected %0d, got %0d", e.maxv, mx);
        errors++;
      end
      if (mn !== e.minv) begin
        $error("running_min: expected %0d, got %0d", e.minv, mn);
        errors++;
      end
    endfunction

    function int pending();
      return result_q.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       channel;
  logic [SAMPLE_W-1:0]        sample;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_channel;
  logic [SAMPLE_W-1:0]        mean_raw;
  logic signed [SCALED_W-1:0] scaled;
  logic signed [SCALED_W-1:0] running_max;
  logic signed [SCALED_W-1:0] running_min;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_data;

  avg_scoreboard sb = new();

  bit tx_idle;
  bit rx_idle;
  bit stall_req;
  int idle_cycles;

  dual_channel_moving_average_scaler_top #(
    .WINDOW(WIN)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .channel    (channel),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_channel(out_channel),
    .mean_raw   (mean_raw),
    .scaled     (scaled),
    .running_max(running_max),
    .running_min(running_min),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_channel, mean_raw, scaled, running_max, running_min);
      end
      if (in_valid && in_ready) begin
        sb.note_input(channel, sample);
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      gap = rx_idle ? $urandom_range(0, 16) : 0;
      if (stall_req) begin
        gap       = STALL_CYCLES;
        stall_req = 1'b0;
      end
      @(negedge clk);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic ch, input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= smp;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(logic ch);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ((ch == dcmas_pkg::CH_TEMP) ? dcmas_pkg::TEMP_PRESET : dcmas_pkg::HUM_PRESET)
                + SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
      3: return SAMPLE_W'($urandom_range(0, 255));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_cfg();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return CFG_W'($urandom_range(0, 512));
      default: return CFG_W'($urandom);
    endcase
  endfunction

  initial begin
    bit ch;
    rst       = 1'b1;
    in_valid  = 1'b0;
    channel   = dcmas_pkg::CH_TEMP;
    sample    = '0;
    cfg_we    = 1'b0;
    cfg_index = dcmas_pkg::REG_TEMP_GAIN;
    cfg_data  = '0;
    tx_idle   = 1'b1;
    rx_idle   = 1'b1;
    stall_req = 1'b0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: extremes of the sample range on both channels
    write_reg(REG_UNUSED, '1);
    send_item(dcmas_pkg::CH_TEMP, '0);
    send_item(dcmas_pkg::CH_TEMP, '1);
    send_item(dcmas_pkg::CH_HUM, '0);
    send_item(dcmas_pkg::CH_HUM, '1);
    settle();

    // largest gains, no offset: windows fill with full-scale samples
    write_reg(dcmas_pkg::REG_TEMP_GAIN, '1);
    write_reg(dcmas_pkg::REG_TEMP_OFFSET, '0);
    write_reg(dcmas_pkg::REG_HUM_GAIN, '1);
    for (int i = 0; i < WIN; i++) begin
      send_item(dcmas_pkg::CH_TEMP, '1);
      send_item(dcmas_pkg::CH_HUM, '1);
    end
    settle();

    // zero gain, largest offset: most negative scaled value
    write_reg(dcmas_pkg::REG_TEMP_GAIN, '0);
    write_reg(dcmas_pkg::REG_TEMP_OFFSET, '1);
    write_reg(dcmas_pkg::REG_HUM_GAIN, '0);
    send_item(dcmas_pkg::CH_TEMP, '0);
    send_item(dcmas_pkg::CH_HUM, '0);
    settle();

    for (int p = 0; p < 5; p++) begin
      write_reg(dcmas_pkg::REG_TEMP_GAIN, pick_cfg());
      write_reg(dcmas_pkg::REG_TEMP_OFFSET, pick_cfg());
      write_reg(dcmas_pkg::REG_HUM_GAIN, pick_cfg());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, pick_cfg());
      tx_idle = (p != 1) && (p != 2);
      rx_idle = (p != 1) && (p != 3);
      if (p == 2) stall_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        ch = 1'($urandom_range(0, 1));
        send_item(ch, pick_sample(ch));
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
